@@ src/assert_macros.svh @@
// Assertion macros used by the filter datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif
`endif

@@ src/wfilt_pkg.sv @@
// Package: constants, codes and control types of the windowed sensor filter.
package wfilt_pkg;
  localparam int WINDOW_MAX  = 32;
  localparam int SAMPLE_BITS = 32;
  localparam int SUM_BITS    = 37;
  localparam int ALPHA_BITS  = 17;
  localparam int ALPHA_ONE   = 65536;
  localparam int IDX_BITS    = 5;
  localparam int CNT_BITS    = 6;
  localparam int MODE_BITS   = 2;
  localparam int REG_BITS    = 2;
  localparam int DIV_STEPS   = SUM_BITS;
  localparam int PROD_BITS   = SAMPLE_BITS + 1 + ALPHA_BITS + 1;

  // filter modes
  localparam logic [MODE_BITS-1:0] MODE_LP   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_HP   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_AVG  = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_PASS = 2'd3;

  // request kinds
  localparam logic REQ_FILTER = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // register indexes
  localparam logic [REG_BITS-1:0] REG_MODE     = 2'd0;
  localparam logic [REG_BITS-1:0] REG_WINDOW   = 2'd1;
  localparam logic [REG_BITS-1:0] REG_LP_ALPHA = 2'd2;
  localparam logic [REG_BITS-1:0] REG_HP_ALPHA = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_POP_RD, ST_POP_SUB, ST_AVG_CHK, ST_AVG_WR,
    ST_DIV_START, ST_DIV, ST_DIV_FIX, ST_L_START, ST_L_INIT, ST_L_MUL,
    ST_L_ACC, ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CLEAR, OP_LP_PUSH, OP_AVG_FIRST, OP_POP_SUB,
    OP_AVG_WR, OP_DIV_START, OP_DIV_STEP, OP_DIV_FIX, OP_LOOP_INIT,
    OP_LOOP_MUL, OP_LOOP_ACC, OP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {
    RD_OLDEST, RD_K, RD_K1
  } rd_sel_t;

  typedef struct packed {
    dp_op_t  op;
    rd_sel_t rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic                 req_clear;
    logic [MODE_BITS-1:0] mode;
    logic                 count_zero;
    logic                 count_full;
    logic                 count_ge2;
    logic                 div_last;
    logic                 loop_last;
    logic                 out_free;
  } dp_status_t;
endpackage

@@ src/wfilt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module wfilt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/wfilt_ctrl.sv @@
// Controller state machine: sequences load, window update, loop and divide.
module wfilt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  wfilt_pkg::dp_status_t  status,
  output wfilt_pkg::dp_cmd_t     cmd
);
  import wfilt_pkg::*;

  state_t state, state_next;
  logic   second_pop;

  // state register and pop pass flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      second_pop <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DECODE) begin
        second_pop <= 1'b0;
      end else if (state == ST_AVG_CHK) begin
        second_pop <= 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (status.req_clear == REQ_CLEAR) begin
          state_next = ST_FINISH;
        end else begin
          case (status.mode)
            MODE_PASS: state_next = ST_FINISH;
            MODE_AVG: begin
              if (status.count_zero)      state_next = ST_FINISH;
              else if (status.count_full) state_next = ST_POP_RD;
              else                        state_next = ST_AVG_WR;
            end
            default: state_next = ST_L_START;
          endcase
        end
      end
      ST_POP_RD:    state_next = ST_POP_SUB;
      ST_POP_SUB:   state_next = second_pop ? ST_AVG_WR : ST_AVG_CHK;
      ST_AVG_CHK:   state_next = status.count_full ? ST_POP_RD : ST_AVG_WR;
      ST_AVG_WR:    state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV;
      ST_DIV: begin
        if (status.div_last) state_next = ST_DIV_FIX;
      end
      ST_DIV_FIX:   state_next = ST_FINISH;
      ST_L_START:   state_next = status.count_ge2 ? ST_L_INIT : ST_FINISH;
      ST_L_INIT:    state_next = ST_L_MUL;
      ST_L_MUL:     state_next = ST_L_ACC;
      ST_L_ACC:     state_next = status.loop_last ? ST_FINISH : ST_L_MUL;
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // command outputs; no transaction is taken while reset is held
  always_comb begin
    cmd.op     = OP_NONE;
    cmd.rd_sel = RD_OLDEST;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = !rst;
        if (s_tvalid && !rst) cmd.op = OP_LOAD;
      end
      ST_DECODE: begin
        if (status.req_clear == REQ_CLEAR) begin
          cmd.op = OP_CLEAR;
        end else begin
          case (status.mode)
            MODE_PASS: cmd.op = OP_NONE;
            MODE_AVG:  cmd.op = status.count_zero ? OP_AVG_FIRST : OP_NONE;
            default:   cmd.op = OP_LP_PUSH;
          endcase
        end
      end
      ST_POP_SUB:   cmd.op = OP_POP_SUB;
      ST_AVG_WR:    cmd.op = OP_AVG_WR;
      ST_DIV_START: cmd.op = OP_DIV_START;
      ST_DIV:       cmd.op = OP_DIV_STEP;
      ST_DIV_FIX:   cmd.op = OP_DIV_FIX;
      ST_L_INIT: begin
        cmd.op     = OP_LOOP_INIT;
        cmd.rd_sel = RD_K1;
      end
      ST_L_MUL: begin
        cmd.op     = OP_LOOP_MUL;
        cmd.rd_sel = RD_K;
      end
      ST_L_ACC: begin
        cmd.op     = OP_LOOP_ACC;
        cmd.rd_sel = RD_K1;
      end
      ST_FINISH: begin
        if (status.out_free) cmd.op = OP_EMIT;
      end
      default: cmd.op = OP_NONE;
    endcase
  end
endmodule

@@ src/wfilt_datapath.sv @@
// Datapath: configuration, window ring store, filter arithmetic, divider, output.
`include "assert_macros.svh"
module wfilt_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wfilt_pkg::REG_BITS-1:0]      cfg_index,
  input  logic [wfilt_pkg::ALPHA_BITS-1:0]    cfg_wdata,
  input  logic                                in_req,
  input  logic [wfilt_pkg::SAMPLE_BITS-1:0]   in_sample,
  input  wfilt_pkg::dp_cmd_t                  cmd,
  output wfilt_pkg::dp_status_t               status,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [wfilt_pkg::SAMPLE_BITS-1:0]   m_tdata,
  output logic                                m_tuser
);
  import wfilt_pkg::*;

  localparam int SHIFT_BITS = PROD_BITS - 16;
  localparam int HSUM_BITS  = SHIFT_BITS + 1;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // configuration
  logic [MODE_BITS-1:0]  mode;
  logic [CNT_BITS-1:0]   wsize;
  logic [ALPHA_BITS-1:0] lp_alpha;
  logic [ALPHA_BITS-1:0] hp_alpha;

  // window state
  logic [IDX_BITS-1:0]   oldest;
  logic [CNT_BITS-1:0]   count;
  logic [SUM_BITS-1:0]   sum;

  // working registers
  logic                          req;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] y;
  logic signed [SAMPLE_BITS-1:0] prev;
  logic signed [SAMPLE_BITS-1:0] cur;
  logic [CNT_BITS-1:0]           k;
  logic signed [PROD_BITS-1:0]   p1;
  logic signed [PROD_BITS-1:0]   p2;

  // divider
  logic [SUM_BITS-1:0]   dq;
  logic [CNT_BITS:0]     rem;
  logic [CNT_BITS-1:0]   dcnt;
  logic                  dneg;

  // RAM ports
  logic                   ram_we;
  logic [IDX_BITS-1:0]    ram_waddr;
  logic [IDX_BITS-1:0]    ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  wfilt_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_MAX)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (x),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // effective window and alpha
  logic [CNT_BITS-1:0]        eff;
  logic [ALPHA_BITS-1:0]      alpha_raw;
  logic [ALPHA_BITS-1:0]      alpha;
  logic signed [ALPHA_BITS:0] alpha_s;
  logic                       full;

  always_comb begin
    if (wsize == '0)                        eff = CNT_BITS'(1);
    else if (wsize > CNT_BITS'(WINDOW_MAX)) eff = CNT_BITS'(WINDOW_MAX);
    else                                    eff = wsize;
    alpha_raw = (mode == MODE_LP) ? lp_alpha : hp_alpha;
    alpha     = (alpha_raw > ALPHA_BITS'(ALPHA_ONE)) ? ALPHA_BITS'(ALPHA_ONE) : alpha_raw;
    alpha_s   = $signed({1'b0, alpha});
    full      = count >= eff;
  end

  // RAM addressing
  logic [CNT_BITS-1:0] k1;
  assign k1        = k + CNT_BITS'(1);
  assign ram_waddr = oldest + count[IDX_BITS-1:0];
  assign ram_we    = (cmd.op == OP_LP_PUSH) || (cmd.op == OP_AVG_FIRST) ||
                     (cmd.op == OP_AVG_WR);

  always_comb begin
    case (cmd.rd_sel)
      RD_K:    ram_raddr = oldest + k[IDX_BITS-1:0];
      RD_K1:   ram_raddr = oldest + k1[IDX_BITS-1:0];
      default: ram_raddr = oldest;
    endcase
  end

  // loop arithmetic operands
  logic signed [SAMPLE_BITS:0]   xi_e;
  logic signed [SAMPLE_BITS:0]   d1;
  logic signed [SAMPLE_BITS:0]   d2;
  logic signed [SHIFT_BITS-1:0]  sh1;
  logic signed [SHIFT_BITS-1:0]  sh2;
  logic signed [HSUM_BITS-1:0]   hsum;
  logic signed [SAMPLE_BITS-1:0] hp_y;
  logic signed [SAMPLE_BITS-1:0] lp_y;

  always_comb begin
    xi_e = $signed({ram_rdata[SAMPLE_BITS-1], ram_rdata});
    d1   = (mode == MODE_LP) ? (xi_e - $signed({y[SAMPLE_BITS-1], y}))
                             : $signed({y[SAMPLE_BITS-1], y});
    d2   = xi_e - $signed({prev[SAMPLE_BITS-1], prev});
    sh1  = p1[PROD_BITS-1:16];
    sh2  = p2[PROD_BITS-1:16];
    lp_y = y + sh1[SAMPLE_BITS-1:0];
    hsum = $signed({sh1[SHIFT_BITS-1], sh1}) + $signed({sh2[SHIFT_BITS-1], sh2});
    if (hsum > HSUM_BITS'(SAMPLE_MAX))      hp_y = SAMPLE_MAX;
    else if (hsum < HSUM_BITS'(SAMPLE_MIN)) hp_y = SAMPLE_MIN;
    else                                    hp_y = hsum[SAMPLE_BITS-1:0];
  end

  // divider step and final quotient
  logic [CNT_BITS:0]         r2;
  logic                      ge;
  logic [SUM_BITS-1:0]       sum_abs;
  logic [SAMPLE_BITS-1:0]    qlo;
  logic signed [SAMPLE_BITS-1:0] q_y;

  always_comb begin
    r2      = {rem[CNT_BITS-1:0], dq[SUM_BITS-1]};
    ge      = r2 >= {1'b0, count};
    sum_abs = sum[SUM_BITS-1] ? (~sum + SUM_BITS'(1)) : sum;
    qlo     = dq[SAMPLE_BITS-1:0];
    if (!dneg) begin
      q_y = (dq > SUM_BITS'(SAMPLE_MAX)) ? SAMPLE_MAX : $signed(qlo);
    end else begin
      q_y = (dq > {{(SUM_BITS-SAMPLE_BITS){1'b0}}, SAMPLE_MIN}) ? SAMPLE_MIN
                                                               : $signed(~qlo + 1'b1);
    end
  end

  // ready flag
  logic [CNT_BITS+3:0] cnt10;
  assign cnt10 = (CNT_BITS+4)'(count) * (CNT_BITS+4)'(10);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_LP;
      wsize    <= CNT_BITS'(16);
      lp_alpha <= ALPHA_BITS'(32768);
      hp_alpha <= ALPHA_BITS'(32768);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:     mode     <= cfg_wdata[MODE_BITS-1:0];
        REG_WINDOW:   wsize    <= cfg_wdata[CNT_BITS-1:0];
        REG_LP_ALPHA: lp_alpha <= cfg_wdata;
        REG_HP_ALPHA: hp_alpha <= cfg_wdata;
        default:      mode     <= mode;
      endcase
    end
  end

  // window control state
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
      count  <= '0;
      sum    <= '0;
    end else begin
      case (cmd.op)
        OP_CLEAR: begin
          oldest <= '0;
          count  <= '0;
          sum    <= '0;
        end
        OP_LP_PUSH: begin
          if (full) oldest <= oldest + IDX_BITS'(1);
          else      count  <= count + CNT_BITS'(1);
        end
        OP_AVG_FIRST: begin
          count <= CNT_BITS'(1);
          sum   <= {{(SUM_BITS-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
        end
        OP_POP_SUB: begin
          sum    <= sum - {{(SUM_BITS-SAMPLE_BITS){ram_rdata[SAMPLE_BITS-1]}}, ram_rdata};
          oldest <= oldest + IDX_BITS'(1);
          count  <= count - CNT_BITS'(1);
        end
        OP_AVG_WR: begin
          count <= count + CNT_BITS'(1);
          sum   <= sum + {{(SUM_BITS-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
        end
        default: count <= count;
      endcase
    end
  end

  // working registers (payload, no reset)
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        req <= in_req;
        x   <= $signed(in_sample);
        y   <= $signed(in_sample);
        k   <= '0;
      end
      OP_CLEAR:     y <= '0;
      OP_DIV_START: begin
        dq   <= sum_abs;
        dneg <= sum[SUM_BITS-1];
        rem  <= '0;
        dcnt <= '0;
      end
      OP_DIV_STEP: begin
        rem  <= ge ? (r2 - {1'b0, count}) : r2;
        dq   <= {dq[SUM_BITS-2:0], ge};
        dcnt <= dcnt + CNT_BITS'(1);
      end
      OP_DIV_FIX:   y <= q_y;
      OP_LOOP_INIT: begin
        y    <= $signed(ram_rdata);
        prev <= $signed(ram_rdata);
        k    <= CNT_BITS'(1);
      end
      OP_LOOP_MUL: begin
        p1  <= d1 * alpha_s;
        p2  <= d2 * alpha_s;
        cur <= $signed(ram_rdata);
      end
      OP_LOOP_ACC: begin
        y    <= (mode == MODE_LP) ? lp_y : hp_y;
        prev <= cur;
        k    <= k1;
      end
      default: k <= k;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      m_tdata <= y;
      m_tuser <= cnt10 >= (CNT_BITS+4)'(eff);
    end
  end

  // status to controller
  always_comb begin
    status.req_clear  = req;
    status.mode       = mode;
    status.count_zero = count == '0;
    status.count_full = full;
    status.count_ge2  = count >= CNT_BITS'(2);
    status.div_last   = dcnt == CNT_BITS'(DIV_STEPS - 1);
    status.loop_last  = k1 == count;
    status.out_free   = !m_tvalid || m_tready;
  end

  `ASSERT_ALWAYS(a_count_max, clk, rst, count <= CNT_BITS'(WINDOW_MAX))
  `ASSERT_IMPLIES(a_emit_free, clk, rst, cmd.op == OP_EMIT, !m_tvalid || m_tready)
  `ASSERT_IMPLIES(a_div_range, clk, rst, cmd.op == OP_DIV_STEP, dcnt < CNT_BITS'(DIV_STEPS))
endmodule

@@ src/windowed_sensor_filter.sv @@
// Top level of the windowed sensor filter: controller, datapath and window RAM.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata sample, s_tuser req_type
//  m_      | out       | m_tvalid/m_tready  | m_tdata filtered, m_tuser ready_res
//  cfg_    | in        | cfg_we             | cfg_index, cfg_wdata
//
// One transaction at a time. Clear, pass-through and the first average sample
// go from decode straight to the output; later averages take none, one or two
// window pops, then the 37-step restoring divider. Low-pass and high-pass walk
// the window RAM when two or more samples are stored (one stored sample is the
// result), reading each sample and multiplying for all but the oldest.
// A new transaction is taken while the last result waits in the output register;
// a stalled output holds the finished item in its last state. Reset (rst,
// synchronous) empties the window and holds s_tready low.
module windowed_sensor_filter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [wfilt_pkg::SAMPLE_BITS-1:0]   s_tdata,   // [31:0] sample
  input  logic                                s_tuser,   // [0] req_type
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [wfilt_pkg::SAMPLE_BITS-1:0]   m_tdata,   // [31:0] filtered
  output logic                                m_tuser,   // [0] ready_res
  input  logic                                cfg_we,
  input  logic [wfilt_pkg::REG_BITS-1:0]      cfg_index,
  input  logic [wfilt_pkg::ALPHA_BITS-1:0]    cfg_wdata
);
  import wfilt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  wfilt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  wfilt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_req    (s_tuser),
    .in_sample (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );
endmodule

@@ tb/windowed_sensor_filter_tb.sv @@
// Testbench of the windowed sensor filter: directed and random stream traffic, scoreboard prediction.
`timescale 1ns / 100ps

module windowed_sensor_filter_tb;
  import wfilt_pkg::*;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] filtered;
    logic                   win_ready;
  } filt_result_t;

  // Filter prediction and result checking
  class filter_scoreboard;
    logic [MODE_BITS-1:0]  mode;
    logic [CNT_BITS-1:0]   win_size;
    logic [ALPHA_BITS-1:0] lp_alpha;
    logic [ALPHA_BITS-1:0] hp_alpha;
    longint                ring[WINDOW_MAX];
    int unsigned           head;
    int unsigned           fill;
    logic [SUM_BITS-1:0]   sum;
    filt_result_t          expected_q[$];
    int                    mismatches;
    int                    checked;

    function new();
      mode = MODE_LP;
      win_size = 16;
      lp_alpha = 32768;
      hp_alpha = 32768;
      head = 0;
      fill = 0;
      sum = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [REG_BITS-1:0] idx, logic [ALPHA_BITS-1:0] val);
      case (idx)
        REG_MODE:     mode = val[MODE_BITS-1:0];
        REG_WINDOW:   win_size = val[CNT_BITS-1:0];
        REG_LP_ALPHA: lp_alpha = val;
        default:      hp_alpha = val;
      endcase
    endfunction

    function int unsigned eff_window();
      if (win_size == 0) return 1;
      return (win_size > WINDOW_MAX) ? WINDOW_MAX : win_size;
    endfunction

    function longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint nth(int unsigned k);
      return ring[(head + k) % WINDOW_MAX];
    endfunction

    function void drop_oldest(bit track);
      if (fill == 0) return;
      if (track) sum = sum - SUM_BITS'(ring[head]);
      head = (head + 1) % WINDOW_MAX;
      fill--;
    endfunction

    function void store(longint x, bit track);
      if (fill >= eff_window()) drop_oldest(track);
      ring[(head + fill) % WINDOW_MAX] = x;
      fill++;
    endfunction

    // Work out the result of one accepted request
    function void note_input(logic req, logic [SAMPLE_BITS-1:0] data);
      longint x, y, a;
      filt_result_t r;
      x = longint'($signed(data));
      y = x;
      if (req == REQ_CLEAR) begin
        fill = 0;
        head = 0;
        sum = '0;
        y = 0;
      end else if (mode == MODE_LP || mode == MODE_HP) begin
        a = (mode == MODE_LP) ? lp_alpha : hp_alpha;
        if (a > ALPHA_ONE) a = ALPHA_ONE;
        store(x, 1'b0);
        if (fill >= 2) begin
          y = nth(0);
          for (int unsigned k = 1; k < fill; k++) begin
            if (mode == MODE_LP)
              y = y + ((a * (nth(k) - y)) >>> 16);
            else
              y = clamp(((a * y) >>> 16) + ((a * (nth(k) - nth(k - 1))) >>> 16));
          end
        end
      end else if (mode == MODE_AVG) begin
        if (fill == 0) begin
          store(x, 1'b1);
          sum = SUM_BITS'(x);
        end else begin
          if (fill >= eff_window()) drop_oldest(1'b1);
          store(x, 1'b1);
          sum = sum + SUM_BITS'(x);
          y = clamp(longint'($signed(sum)) / longint'(fill));
        end
      end
      r.filtered = y[SAMPLE_BITS-1:0];
      r.win_ready = (fill * 10 >= eff_window());
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [SAMPLE_BITS-1:0] data, logic flag);
      filt_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h/%b", data, flag);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (e.filtered !== data || e.win_ready !== flag) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: expected filtered %h ready %b, got %h ready %b",
                   checked, e.filtered, e.win_ready, data, flag);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [SAMPLE_BITS-1:0] s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [SAMPLE_BITS-1:0] m_tdata;
  logic                   m_tuser;
  logic                   cfg_we = 1'b0;
  logic [REG_BITS-1:0]    cfg_index = '0;
  logic [ALPHA_BITS-1:0]  cfg_wdata = '0;

  filter_scoreboard sb = new();
  bit               gaps_on = 1'b1;
  int               sent = 0;
  int               clears = 0;
  int               phases = 0;
  int               stall_left = 0;

  always #6 clk = ~clk;

  windowed_sensor_filter dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Output side: check each transaction, stall in bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Send one request; valid stays high unless a gap follows
  task automatic send_req(logic req, logic [SAMPLE_BITS-1:0] data);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(req, data);
    sent++;
    if (req == REQ_CLEAR) clears++;
  endtask

  // Drain the block, then write all four registers
  task automatic configure(logic [1:0] md, logic [5:0] ws, logic [16:0] la, logic [16:0] ha);
    logic [ALPHA_BITS-1:0] vals[4];
    vals = '{ALPHA_BITS'(md), ALPHA_BITS'(ws), la, ha};
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_BITS'(i);
      cfg_wdata <= vals[i];
      sb.set_reg(REG_BITS'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    phases++;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      1, 2:    return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] rand_window();
    case ($urandom_range(0, 9))
      0:       return 6'd0;
      1:       return 6'($urandom_range(33, 63));
      2:       return 6'd32;
      3:       return 6'd1;
      default: return 6'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [16:0] rand_alpha();
    case ($urandom_range(0, 7))
      0:       return 17'd0;
      1:       return 17'd65536;
      2:       return 17'($urandom_range(65537, 131071));
      3:       return 17'd1;
      default: return 17'($urandom_range(1, 65535));
    endcase
  endfunction

  // Stimulus
  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes in each mode, clear, saturating alphas and odd window sizes
    configure(MODE_LP, 6'd4, 17'd65536, 17'd0);
    send_req(REQ_FILTER, 32'h7fffffff);
    send_req(REQ_FILTER, 32'h80000000);
    send_req(REQ_FILTER, 32'h00000000);
    send_req(REQ_FILTER, 32'hffffffff);
    send_req(REQ_FILTER, 32'h00000001);
    send_req(REQ_CLEAR, 32'h12345678);
    configure(MODE_HP, 6'd4, 17'd1, 17'd65536);
    send_req(REQ_FILTER, 32'h80000000);
    send_req(REQ_FILTER, 32'h7fffffff);
    send_req(REQ_FILTER, 32'h80000000);
    send_req(REQ_FILTER, 32'h7fffffff);
    configure(MODE_HP, 6'd0, 17'd131071, 17'd0);
    send_req(REQ_FILTER, 32'h00010000);
    send_req(REQ_FILTER, 32'hfffe0000);
    configure(MODE_AVG, 6'd3, 17'd131071, 17'd131071);
    send_req(REQ_FILTER, 32'h7fffffff);
    send_req(REQ_FILTER, 32'h7fffffff);
    send_req(REQ_FILTER, 32'h7fffffff);
    send_req(REQ_FILTER, 32'h80000000);
    send_req(REQ_FILTER, 32'hffffffff);
    configure(MODE_AVG, 6'd1, 17'd1, 17'd1);
    send_req(REQ_FILTER, 32'hfffffffd);
    configure(MODE_PASS, 6'd63, 17'd32768, 17'd32768);
    send_req(REQ_FILTER, 32'h80000000);
    send_req(REQ_CLEAR, 32'h7fffffff);
    send_req(REQ_FILTER, 32'h5a5aa5a5);

    // random phases; the window often shrinks under a filled store
    while (sent < 1300) begin
      if (sent > 1150) gaps_on = 1'b0;
      configure(2'($urandom_range(0, 3)), rand_window(), rand_alpha(), rand_alpha());
      n = $urandom_range(10, 50);
      for (int i = 0; i < n; i++)
        send_req(($urandom_range(0, 24) == 0) ? REQ_CLEAR : REQ_FILTER, rand_sample());
    end

    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Sent %0d requests (%0d clears) over %0d register settings, checked %0d results",
             sent, clears, phases, sb.checked);
    $display("Mismatches: %0d, results still expected: %0d", sb.mismatches,
             sb.expected_q.size());
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Timeout
  initial begin
    #20ms;
    $display("Timeout after %0d requests", sent);
    $display("Test completed with failures");
    $finish;
  end

endmodule
